FILE: rtl/core/spadd_pkg.sv
// Shared types and codes for the sparse polynomial adder.
// No dependencies; compile first.
package spadd_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2
  } action_e;

  localparam int unsigned CoefW   = 16;
  localparam int unsigned ExponW  = 16;
  localparam int unsigned SumW    = CoefW + 1;

  // One stored term, as it sits in a list memory.
  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic [ExponW-1:0]       expon;
  } term_t;

  // One result item.
  typedef struct packed {
    logic signed [SumW-1:0] coef_out;
    logic [ExponW-1:0]      expon_out;
    logic                   term_valid;
    logic                   last;
    logic                   overflow;
  } res_t;

endpackage

FILE: rtl/core/spadd_in_if.sv
// Input channel of the sparse polynomial adder: valid/ready plus one load or start item.
// Depends on spadd_pkg.
interface spadd_in_if;
  import spadd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic signed [CoefW-1:0] coef_in;
  logic [ExponW-1:0]       expon_in;

  modport source (output valid, output action, output coef_in, output expon_in,
                  input ready);
  modport sink   (input valid, input action, input coef_in, input expon_in,
                  output ready);
endinterface

FILE: rtl/core/spadd_out_if.sv
// Output channel of the sparse polynomial adder: valid/ready plus one result term.
// Depends on spadd_pkg.
interface spadd_out_if;
  import spadd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [SumW-1:0] coef_out;
  logic [ExponW-1:0]      expon_out;
  logic                   term_valid;
  logic                   last;
  logic                   overflow;

  modport source (output valid, output coef_out, output expon_out, output term_valid,
                  output last, output overflow, input ready);
  modport sink   (input valid, input coef_out, input expon_out, input term_valid,
                  input last, input overflow, output ready);
endinterface

FILE: rtl/core/spadd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module spadd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/spadd_merge.sv
// Merge sequencer: walks both term lists, adds matching terms, holds one term back to
// find the last one, and drives the output register. Depends on spadd_pkg.
module spadd_merge #(
  parameter int unsigned MaxTerms = 32,
  localparam int unsigned AddrW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1,
  localparam int unsigned CntW  = $clog2(MaxTerms + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CntW-1:0]     a_cnt_i,
  input  logic [CntW-1:0]     b_cnt_i,
  input  logic                overflow_i,
  output logic [AddrW-1:0]    a_raddr_o,
  output logic [AddrW-1:0]    b_raddr_o,
  input  spadd_pkg::term_t    a_rdata_i,
  input  spadd_pkg::term_t    b_rdata_i,
  output logic                busy_o,
  output logic                done_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spadd_pkg::res_t     out_data_o
);
  import spadd_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        i_q, i_d, j_q, j_d;
  logic                   pend_vld_q, pend_vld_d;
  logic signed [SumW-1:0] pend_coef_q, pend_coef_d;
  logic [ExponW-1:0]      pend_expon_q, pend_expon_d;
  logic                   out_vld_q, out_vld_d;
  res_t                   out_q, out_d;

  logic                   a_left, b_left, out_free;
  logic signed [SumW-1:0] a_ext, b_ext, sum;
  logic                   cand_emit, adv_a, adv_b;
  logic signed [SumW-1:0] cand_coef;
  logic [ExponW-1:0]      cand_expon;

  assign a_left   = (i_q < a_cnt_i);
  assign b_left   = (j_q < b_cnt_i);
  assign out_free = !out_vld_q || out_ready_i;
  assign a_ext    = SumW'(a_rdata_i.coef);
  assign b_ext    = SumW'(b_rdata_i.coef);
  assign sum      = a_ext + b_ext;

  // Pick the next term from the heads of both lists.
  always_comb begin
    cand_emit  = 1'b1;
    cand_coef  = a_ext;
    cand_expon = a_rdata_i.expon;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    priority if (a_left && b_left) begin
      if (a_rdata_i.expon == b_rdata_i.expon) begin
        cand_emit = (sum != '0);
        cand_coef = sum;
        adv_a     = 1'b1;
        adv_b     = 1'b1;
      end else if (a_rdata_i.expon > b_rdata_i.expon) begin
        adv_a = 1'b1;
      end else begin
        cand_coef  = b_ext;
        cand_expon = b_rdata_i.expon;
        adv_b      = 1'b1;
      end
    end else if (a_left) begin
      adv_a = 1'b1;
    end else begin
      cand_coef  = b_ext;
      cand_expon = b_rdata_i.expon;
      adv_b      = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    pend_vld_d   = pend_vld_q;
    pend_coef_d  = pend_coef_q;
    pend_expon_d = pend_expon_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_d        = out_q;
    done_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          i_d        = '0;
          j_d        = '0;
          pend_vld_d = 1'b0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (a_left || b_left) begin
          // Hold the walk while the held-back term has nowhere to go.
          if (!(cand_emit && pend_vld_q && !out_free)) begin
            if (adv_a) i_d = i_q + CntW'(1);
            if (adv_b) j_d = j_q + CntW'(1);
            if (cand_emit) begin
              if (pend_vld_q) begin
                out_vld_d = 1'b1;
                out_d     = '{coef_out: pend_coef_q, expon_out: pend_expon_q,
                              term_valid: 1'b1, last: 1'b0, overflow: overflow_i};
              end
              pend_vld_d   = 1'b1;
              pend_coef_d  = cand_coef;
              pend_expon_d = cand_expon;
            end
          end
        end else if (out_free) begin
          // Both lists drained: flush the held term as last, or flag an empty result.
          out_vld_d  = 1'b1;
          out_d      = '{coef_out: pend_vld_q ? pend_coef_q : '0,
                         expon_out: pend_vld_q ? pend_expon_q : '0,
                         term_valid: pend_vld_q, last: 1'b1, overflow: overflow_i};
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
          done_o     = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Read the entry the indices will point at next, so the registered read data lines up with them.
  assign a_raddr_o   = i_d[AddrW-1:0];
  assign b_raddr_o   = j_d[AddrW-1:0];
  assign busy_o      = (state_q == ST_RUN);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      i_q          <= '0;
      j_q          <= '0;
      pend_vld_q   <= 1'b0;
      pend_coef_q  <= '0;
      pend_expon_q <= '0;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      j_q          <= j_d;
      pend_vld_q   <= pend_vld_d;
      pend_coef_q  <= pend_coef_d;
      pend_expon_q <= pend_expon_d;
      out_vld_q    <= out_vld_d;
      out_q        <= out_d;
    end
  end

endmodule

FILE: rtl/core/sparse_polynomial_add_top.sv
// Sparse polynomial adder, top level. Depends on spadd_pkg, spadd_in_if, spadd_out_if,
// spadd_ram and spadd_merge.
//
// Load items (action A or B) append one term to list A or B; each list holds up to
// MAX_TERMS terms in a synchronous RAM, and a load into a full list is dropped and sets a
// sticky overflow flag that only reset clears. Loads transfer one per cycle and produce no
// result. A start item merges the two lists, expected in descending exponent order: equal
// exponents add (a zero sum is dropped), otherwise the larger exponent goes first, and the
// rest of either list follows. Results come out one per transfer with coef_out widened to
// 17 bits; the final one carries last, and a run with no surviving term gives a single item
// with term_valid low. Every result carries the current overflow flag. The merge walks the
// lists one step per cycle unless the output stalls, reading both RAM heads, and the input
// side stays busy, so loads wait, until the walk ends; one term is held back to find the
// last one. Both lists are empty after the run. A result register parts the output from
// the walk, so the next load transfers while a result waits.
module sparse_polynomial_add_top #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spadd_in_if.sink   in_i,
  spadd_out_if.source out_o
);
  import spadd_pkg::*;

  localparam int unsigned AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_TERMS + 1);

  logic [CntW-1:0]  a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic             ovf_q, ovf_d;
  logic             in_xfer, busy, done, start;
  logic             a_we, b_we;
  logic             a_full, b_full;
  logic [AddrW-1:0] a_raddr, b_raddr;
  term_t            a_rdata, b_rdata, wterm;
  res_t             res;

  assign in_i.ready = !busy;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign a_full     = (a_cnt_q >= CntW'(MAX_TERMS));
  assign b_full     = (b_cnt_q >= CntW'(MAX_TERMS));
  assign wterm      = '{coef: in_i.coef_in, expon: in_i.expon_in};

  // Decode the transferred item: append a term or kick off the merge.
  always_comb begin
    a_we    = 1'b0;
    b_we    = 1'b0;
    start   = 1'b0;
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    ovf_d   = ovf_q;
    if (in_xfer) begin
      unique case (in_i.action)
        ACT_LOAD_A: begin
          if (a_full) begin
            ovf_d = 1'b1;
          end else begin
            a_we    = 1'b1;
            a_cnt_d = a_cnt_q + CntW'(1);
          end
        end
        ACT_LOAD_B: begin
          if (b_full) begin
            ovf_d = 1'b1;
          end else begin
            b_we    = 1'b1;
            b_cnt_d = b_cnt_q + CntW'(1);
          end
        end
        ACT_START: start = 1'b1;
        default: ;  // unused code: drop
      endcase
    end
    // Empty both lists once the run has flushed its last result.
    if (done) begin
      a_cnt_d = '0;
      b_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  spadd_ram #(.Width($bits(term_t)), .Depth(MAX_TERMS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_cnt_q[AddrW-1:0]),
    .wdata_i (wterm),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  spadd_ram #(.Width($bits(term_t)), .Depth(MAX_TERMS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_cnt_q[AddrW-1:0]),
    .wdata_i (wterm),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  spadd_merge #(.MaxTerms(MAX_TERMS)) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .a_cnt_i     (a_cnt_q),
    .b_cnt_i     (b_cnt_q),
    .overflow_i  (ovf_q),
    .a_raddr_o   (a_raddr),
    .b_raddr_o   (b_raddr),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .busy_o      (busy),
    .done_o      (done),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res)
  );

  assign out_o.coef_out   = res.coef_out;
  assign out_o.expon_out  = res.expon_out;
  assign out_o.term_valid = res.term_valid;
  assign out_o.last       = res.last;
  assign out_o.overflow   = res.overflow;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for sparse_polynomial_add_top: drives load and start transfers,
// predicts the merged term stream and compares every result field.
// Depends on spadd_pkg, spadd_in_if, spadd_out_if and the adder RTL.
module testbench;
  import spadd_pkg::*;

  localparam int unsigned MaxTerms = 32;
  localparam int unsigned Limit    = 400_000;
  // The one action code the package leaves unused; the adder ignores it.
  localparam logic [1:0]  ActIgnored = 2'd3;
  localparam res_t        NoRes      = '0;

  // One row of the directed table. Loads with reps > 1 step the exponent down by one.
  typedef struct packed {
    logic [1:0]              act;
    logic signed [CoefW-1:0] coef;
    logic [ExponW-1:0]       expon;
    int                      reps;
    bit                      typed;
    res_t                    want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  spadd_in_if  feed_ch ();
  spadd_out_if sum_ch ();

  sparse_polynomial_add_top #(
    .MAX_TERMS(MaxTerms)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (feed_ch),
    .out_o (sum_ch)
  );

  // Predictor state: both term lists, their fill levels and the sticky overflow.
  term_t a_terms [MaxTerms];
  term_t b_terms [MaxTerms];
  int    a_len;
  int    b_len;
  logic  ovf_seen;

  res_t  pending_terms [$];
  int    mismatch_cnt = 0;
  int    fed_cnt;
  int    cycle_cnt = 0;
  bit    calm;

  // Extremes, cancellation, zero coefficient, the unused code, unsorted lists,
  // overflow of list A and a start with both lists empty once overflow is sticky.
  dir_row_t dir_rows [23] = '{
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b1, '{17'sd0,     16'h0000, 1'b0, 1'b1, 1'b0}},
    '{ACT_LOAD_A, 16'sh7FFF, 16'hFFFF, 1,  1'b0, NoRes},
    '{ACT_LOAD_B, 16'sh7FFF, 16'hFFFF, 1,  1'b0, NoRes},
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b1, '{17'sd65534, 16'hFFFF, 1'b1, 1'b1, 1'b0}},
    '{ACT_LOAD_A, 16'sh8000, 16'h0000, 1,  1'b0, NoRes},
    '{ACT_LOAD_B, 16'sh8000, 16'h0000, 1,  1'b0, NoRes},
    '{ACT_START,  16'shFFFF, 16'hFFFF, 1,  1'b1, '{17'h10000,  16'h0000, 1'b1, 1'b1, 1'b0}},
    '{ACT_LOAD_A, 16'sh0005, 16'h0007, 1,  1'b0, NoRes},
    '{ACT_LOAD_B, 16'shFFFB, 16'h0007, 1,  1'b0, NoRes},
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b1, '{17'sd0,     16'h0000, 1'b0, 1'b1, 1'b0}},
    '{ACT_LOAD_A, 16'sh0000, 16'h0064, 1,  1'b0, NoRes},
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b1, '{17'sd0,     16'h0064, 1'b1, 1'b1, 1'b0}},
    '{ActIgnored, 16'sh1234, 16'h5555, 1,  1'b0, NoRes},
    '{ACT_LOAD_B, 16'sh000C, 16'h0032, 1,  1'b0, NoRes},
    '{ACT_LOAD_A, 16'sh0009, 16'h002D, 1,  1'b0, NoRes},
    '{ACT_LOAD_B, 16'sh000B, 16'h0028, 1,  1'b0, NoRes},
    '{ACT_LOAD_A, 16'shFFF4, 16'h0032, 1,  1'b0, NoRes},
    '{ActIgnored, 16'shAAAA, 16'hAAAA, 1,  1'b0, NoRes},
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b0, NoRes},
    '{ACT_LOAD_A, 16'sh0003, 16'h00C8, 34, 1'b0, NoRes},
    '{ACT_LOAD_B, 16'sh0001, 16'h0096, 1,  1'b0, NoRes},
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b0, NoRes},
    '{ACT_START,  16'sh0000, 16'h0000, 1,  1'b1, '{17'sd0,     16'h0000, 1'b0, 1'b1, 1'b1}}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one; none while calm.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic res_t make_term(logic signed [SumW-1:0] c, logic [ExponW-1:0] e,
                                     logic v);
    return '{c, e, v, 1'b0, ovf_seen};
  endfunction

  // Advance the predictor by one accepted transfer and return the terms it emits.
  function automatic void fold_item(logic [1:0] act, logic signed [CoefW-1:0] c,
                                    logic [ExponW-1:0] e, ref res_t outs[$]);
    int i;
    int j;
    logic signed [SumW-1:0] sum;
    i = 0;
    j = 0;
    outs = {};
    case (act)
      ACT_LOAD_A: begin
        if (a_len < MaxTerms) begin
          a_terms[a_len] = '{c, e};
          a_len++;
        end else ovf_seen = 1'b1;
      end
      ACT_LOAD_B: begin
        if (b_len < MaxTerms) begin
          b_terms[b_len] = '{c, e};
          b_len++;
        end else ovf_seen = 1'b1;
      end
      ACT_START: begin
        while (i < a_len && j < b_len) begin
          if (a_terms[i].expon == b_terms[j].expon) begin
            sum = $signed(a_terms[i].coef) + $signed(b_terms[j].coef);
            // a cancelled pair leaves nothing behind
            if (sum != 0) outs.push_back(make_term(sum, a_terms[i].expon, 1'b1));
            i++;
            j++;
          end else if (a_terms[i].expon > b_terms[j].expon) begin
            outs.push_back(make_term($signed(a_terms[i].coef), a_terms[i].expon, 1'b1));
            i++;
          end else begin
            outs.push_back(make_term($signed(b_terms[j].coef), b_terms[j].expon, 1'b1));
            j++;
          end
        end
        for (; i < a_len; i++)
          outs.push_back(make_term($signed(a_terms[i].coef), a_terms[i].expon, 1'b1));
        for (; j < b_len; j++)
          outs.push_back(make_term($signed(b_terms[j].coef), b_terms[j].expon, 1'b1));
        if (outs.size() == 0) outs.push_back(make_term('0, '0, 1'b0));
        outs[outs.size() - 1].last = 1'b1;
        a_len = 0;
        b_len = 0;
      end
      default: ;
    endcase
  endfunction

  // Present one item from the falling edge on and hold it until it transfers.
  // A typed expectation replaces the predicted one; the predictor still advances.
  task automatic send_item(logic [1:0] act, logic signed [CoefW-1:0] c,
                           logic [ExponW-1:0] e, bit typed, res_t want);
    int gap;
    res_t outs[$];
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      feed_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed_ch.valid    <= 1'b1;
    feed_ch.action   <= act;
    feed_ch.coef_in  <= c;
    feed_ch.expon_in <= e;
    @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    fold_item(act, c, e, outs);
    if (typed) pending_terms.push_back(want);
    else foreach (outs[k]) pending_terms.push_back(outs[k]);
    if (act != ActIgnored) fed_cnt++;
  endtask

  // Drop valid and hold until every expected term has come back.
  task automatic hold_off();
    @(negedge clk);
    feed_ch.valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CoefW-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'sh7FFF;
    if (r < 4) return 16'sh8000;
    if (r == 4) return '0;
    return CoefW'($urandom);
  endfunction

  task automatic swap_two(ref term_t q[$]);
    int s0;
    int s1;
    term_t t;
    s0 = $urandom_range(0, q.size() - 1);
    s1 = $urandom_range(0, q.size() - 1);
    t = q[s0];
    q[s0] = q[s1];
    q[s1] = t;
  endtask

  // One polynomial pair: a shared descending exponent walk split between A and B,
  // with matching exponents (some cancelling), sometimes an unsorted list or
  // more terms than fit, stray ignored items in between, then a start.
  task automatic feed_random_pair();
    term_t qa[$];
    term_t qb[$];
    term_t t;
    int n;
    int r;
    int k;
    int cur;
    int step_max;
    int pick;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] c2;
    r = $urandom_range(0, 99);
    n = (r < 80) ? $urandom_range(0, 8) : (r < 93) ? $urandom_range(9, 24) :
        $urandom_range(30, 70);
    cur = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
    step_max = ($urandom_range(0, 3) == 0) ? 4000 : 40;
    for (k = 0; k < n && cur >= 0; k++) begin
      c = pick_coef();
      pick = $urandom_range(0, 2);
      c2 = (pick != 2) ? c : ($urandom_range(0, 2) == 0) ? -c : pick_coef();
      if (pick != 1) qa.push_back('{c, cur[15:0]});
      if (pick != 0) qb.push_back('{c2, cur[15:0]});
      cur -= $urandom_range(1, step_max);
    end
    if (qa.size() > 1 && $urandom_range(0, 7) == 0) swap_two(qa);
    if (qb.size() > 1 && $urandom_range(0, 7) == 0) swap_two(qb);
    while (qa.size() + qb.size() > 0) begin
      if ($urandom_range(0, 11) == 0)
        send_item(ActIgnored, CoefW'($urandom), ExponW'($urandom), 1'b0, NoRes);
      if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1) == 1)) begin
        t = qa.pop_front();
        send_item(ACT_LOAD_A, t.coef, t.expon, 1'b0, NoRes);
      end else begin
        t = qb.pop_front();
        send_item(ACT_LOAD_B, t.coef, t.expon, 1'b0, NoRes);
      end
    end
    if ($urandom_range(0, 5) == 0) hold_off();
    // start ignores its payload, so let it carry noise
    send_item(ACT_START, CoefW'($urandom), ExponW'($urandom), 1'b0, NoRes);
  endtask

  // Result side: bursts of ready with random stalls in between.
  initial begin
    sum_ch.ready = 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk) sum_ch.ready <= 1'b1;
      repeat (idle_len()) @(negedge clk) sum_ch.ready <= 1'b0;
    end
  end

  task automatic cmp_field(string name, logic signed [31:0] w, logic signed [31:0] g);
    if (w !== g) begin
      $display("%0t: %s expected %0d got %0d", $time, name, w, g);
      mismatch_cnt++;
    end
  endtask

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst_n && sum_ch.valid && sum_ch.ready) begin
      seen = '{sum_ch.coef_out, sum_ch.expon_out, sum_ch.term_valid, sum_ch.last,
               sum_ch.overflow};
      if (pending_terms.size() == 0) begin
        $display("%0t: expected no result, got coef %0d expon %0d", $time, seen.coef_out,
                 seen.expon_out);
        mismatch_cnt++;
      end else begin
        want = pending_terms.pop_front();
        cmp_field("coef_out", want.coef_out, seen.coef_out);
        cmp_field("expon_out", want.expon_out, seen.expon_out);
        cmp_field("term_valid", want.term_valid, seen.term_valid);
        cmp_field("last", want.last, seen.last);
        cmp_field("overflow", want.overflow, seen.overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == Limit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int base;
    fed_cnt          = 0;
    calm             = 1'b0;
    a_len            = 0;
    b_len            = 0;
    ovf_seen         = 1'b0;
    rst_n            = 1'b0;
    feed_ch.valid    = 1'b0;
    feed_ch.action   = ACT_LOAD_A;
    feed_ch.coef_in  = '0;
    feed_ch.expon_in = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].reps; k++)
        send_item(dir_rows[r].act, dir_rows[r].coef, dir_rows[r].expon - ExponW'(k),
                  dir_rows[r].typed, dir_rows[r].want);
    hold_off();

    base = fed_cnt;
    while (fed_cnt - base < 150) begin
      calm = ($urandom_range(0, 5) == 0);
      feed_random_pair();
    end
    calm = 1'b0;

    // drain, then leave room for a full merge walk to show anything stray
    hold_off();
    repeat (2 * MaxTerms + 8) @(posedge clk);
    if (mismatch_cnt == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
